/* rtl/complex_arithmetic_unit_macros.svh */
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Checks that a condition implies a property in the same cycle.
`define CAU_ASSERT_IMP(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Checks that a condition implies a property in the next cycle.
`define CAU_ASSERT_NXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

/* rtl/cau_pkg.sv */
`default_nettype none

package cau_pkg;

   localparam int FIELD_W = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   dz;
      logic   neg_re;
      logic   neg_im;
   } ctl_type;

endpackage

`default_nettype wire

/* rtl/cau_front.sv */
`default_nettype none

module cau_front #(
   parameter int DW    = 32,
   parameter int FB    = 16,
   parameter int CW    = 115,
   parameter int RW    = 66
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  wire                           in_valid,
   input  cau_pkg::op_type               in_op,
   input  wire  [cau_pkg::FIELD_W-1:0]   in_a,
   input  wire  [cau_pkg::FIELD_W-1:0]   in_b,
   input  wire  [cau_pkg::FIELD_W-1:0]   in_c,
   input  wire  [cau_pkg::FIELD_W-1:0]   in_d,
   output cau_pkg::ctl_type              out_ctl,
   output logic [RW-1:0]                 out_mag_re,
   output logic [RW-1:0]                 out_mag_im,
   output logic [CW-1:0]                 out_rem_re,
   output logic [CW-1:0]                 out_rem_im,
   output logic [2*DW-1:0]               out_den,
   output logic                          out_big_re,
   output logic                          out_big_im
);
   import cau_pkg::*;

   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int AW = DW + 1;
   localparam logic [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (FB - 1);

   ctl_type s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s2_ctl_in, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff;
   ctl_type s5_ctl_in;

   logic signed [DW-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;

   logic signed [PW-1:0] s2_ac_ff, s2_bd_ff, s2_bc_ff, s2_ad_ff, s2_cc_ff, s2_dd_ff;
   logic signed [AW-1:0] s2_sre_ff, s2_sim_ff, s2_sre_in, s2_sim_in;

   logic signed [SW-1:0] s3_vre_ff, s3_vim_ff, s3_dre_ff, s3_dim_ff;
   logic signed [SW-1:0] s3_vre_in, s3_vim_in;
   logic [PW-1:0]        s3_den_ff, s4_den_ff, s5_den_ff;

   logic [PW-1:0] s4_vre_ff, s4_vim_ff, s4_dre_ff, s4_dim_ff;
   logic          s4_nvre_ff, s4_nvim_ff, s4_ndre_ff, s4_ndim_ff;

   logic [RW-1:0] s5_mre_ff, s5_mim_ff, s5_mre_in, s5_mim_in;
   logic [CW-1:0] s5_rre_ff, s5_rim_ff, s5_rre_in, s5_rim_in, den_sh;
   logic          s5_bre_ff, s5_bim_ff;

   always_comb begin
      s1_ctl_in       = '0;
      s1_ctl_in.valid = in_valid;
      s1_ctl_in.op    = in_op;

      s2_ctl_in    = s1_ctl_ff;
      s2_ctl_in.dz = (s1_ctl_ff.op == OP_DIV) && (s1_c_ff == '0) && (s1_d_ff == '0);
      if (s1_ctl_ff.op == OP_SUB) begin
         s2_sre_in = AW'(s1_a_ff) - AW'(s1_c_ff);
         s2_sim_in = AW'(s1_b_ff) - AW'(s1_d_ff);
      end else begin
         s2_sre_in = AW'(s1_a_ff) + AW'(s1_c_ff);
         s2_sim_in = AW'(s1_b_ff) + AW'(s1_d_ff);
      end

      if (s2_ctl_ff.op == OP_ADD || s2_ctl_ff.op == OP_SUB) begin
         s3_vre_in = SW'(s2_sre_ff);
         s3_vim_in = SW'(s2_sim_ff);
      end else begin
         s3_vre_in = SW'(s2_ac_ff) - SW'(s2_bd_ff);
         s3_vim_in = SW'(s2_bc_ff) + SW'(s2_ad_ff);
      end

      s5_ctl_in = s4_ctl_ff;
      den_sh    = CW'(s4_den_ff) << (DW + 2);
      s5_rre_in = CW'(s4_dre_ff) << (FB + 1);
      s5_rim_in = CW'(s4_dim_ff) << (FB + 1);
      if (s4_ctl_ff.op == OP_DIV) begin
         s5_ctl_in.neg_re = s4_ndre_ff;
         s5_ctl_in.neg_im = s4_ndim_ff;
      end else begin
         s5_ctl_in.neg_re = s4_nvre_ff;
         s5_ctl_in.neg_im = s4_nvim_ff;
      end
      if (s4_ctl_ff.op == OP_MUL) begin
         s5_mre_in = (RW'(s4_vre_ff) + HALF) >> FB;
         s5_mim_in = (RW'(s4_vim_ff) + HALF) >> FB;
      end else begin
         s5_mre_in = RW'(s4_vre_ff);
         s5_mim_in = RW'(s4_vim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s5_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff <= in_a[DW-1:0];
         s1_b_ff <= in_b[DW-1:0];
         s1_c_ff <= in_c[DW-1:0];
         s1_d_ff <= in_d[DW-1:0];

         s2_ac_ff  <= PW'(s1_a_ff) * PW'(s1_c_ff);
         s2_bd_ff  <= PW'(s1_b_ff) * PW'(s1_d_ff);
         s2_bc_ff  <= PW'(s1_b_ff) * PW'(s1_c_ff);
         s2_ad_ff  <= PW'(s1_a_ff) * PW'(s1_d_ff);
         s2_cc_ff  <= PW'(s1_c_ff) * PW'(s1_c_ff);
         s2_dd_ff  <= PW'(s1_d_ff) * PW'(s1_d_ff);
         s2_sre_ff <= s2_sre_in;
         s2_sim_ff <= s2_sim_in;

         s3_vre_ff <= s3_vre_in;
         s3_vim_ff <= s3_vim_in;
         s3_dre_ff <= SW'(s2_ac_ff) + SW'(s2_bd_ff);
         s3_dim_ff <= SW'(s2_bc_ff) - SW'(s2_ad_ff);
         s3_den_ff <= $unsigned(s2_cc_ff) + $unsigned(s2_dd_ff);

         s4_nvre_ff <= s3_vre_ff[SW-1];
         s4_nvim_ff <= s3_vim_ff[SW-1];
         s4_ndre_ff <= s3_dre_ff[SW-1];
         s4_ndim_ff <= s3_dim_ff[SW-1];
         s4_vre_ff  <= s3_vre_ff[SW-1] ? PW'(-s3_vre_ff) : PW'(s3_vre_ff);
         s4_vim_ff  <= s3_vim_ff[SW-1] ? PW'(-s3_vim_ff) : PW'(s3_vim_ff);
         s4_dre_ff  <= s3_dre_ff[SW-1] ? PW'(-s3_dre_ff) : PW'(s3_dre_ff);
         s4_dim_ff  <= s3_dim_ff[SW-1] ? PW'(-s3_dim_ff) : PW'(s3_dim_ff);
         s4_den_ff  <= s3_den_ff;

         s5_mre_ff <= s5_mre_in;
         s5_mim_ff <= s5_mim_in;
         s5_rre_ff <= s5_rre_in;
         s5_rim_ff <= s5_rim_in;
         s5_bre_ff <= s5_rre_in >= den_sh;
         s5_bim_ff <= s5_rim_in >= den_sh;
         s5_den_ff <= s4_den_ff;
      end
   end

   assign out_ctl    = s5_ctl_ff;
   assign out_mag_re = s5_mre_ff;
   assign out_mag_im = s5_mim_ff;
   assign out_rem_re = s5_rre_ff;
   assign out_rem_im = s5_rim_ff;
   assign out_den    = s5_den_ff;
   assign out_big_re = s5_bre_ff;
   assign out_big_im = s5_bim_ff;

endmodule

`default_nettype wire

/* rtl/cau_divider.sv */
`default_nettype none

module cau_divider #(
   parameter int DW = 32,
   parameter int CW = 115
) (
   input  wire               clock,
   input  wire               advance,
   input  wire  [CW-1:0]     rem_in,
   input  wire  [2*DW-1:0]   den_in,
   input  wire               big_in,
   output logic [DW+1:0]     q_out,
   output logic              big_out
);
   import cau_pkg::*;

   localparam int NS = DW + 2;
   localparam int QW = DW + 2;
   localparam int PW = 2 * DW;

   logic [CW-1:0] rem_ff [NS];
   logic [PW-1:0] den_ff [NS];
   logic [QW-1:0] q_ff   [NS];
   logic          big_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam int K = NS - 1 - i;
      logic [CW-1:0] rem_prev;
      logic [PW-1:0] den_prev;
      logic [QW-1:0] q_prev;
      logic          big_prev;
      logic [CW:0]   diff;
      logic          take;

      if (i == 0) begin : g_first
         assign rem_prev = rem_in;
         assign den_prev = den_in;
         assign q_prev   = '0;
         assign big_prev = big_in;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign big_prev = big_ff[i-1];
      end

      assign diff = {1'b0, rem_prev} - {1'b0, CW'(den_prev) << K};
      assign take = !diff[CW];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= take ? diff[CW-1:0] : rem_prev;
            den_ff[i] <= den_prev;
            q_ff[i]   <= {q_prev[QW-2:0], take};
            big_ff[i] <= big_prev;
         end
      end
   end

   assign q_out   = q_ff[NS-1];
   assign big_out = big_ff[NS-1];

endmodule

`default_nettype wire

/* rtl/complex_arithmetic_unit.sv */
// Complex add, subtract, multiply and divide on signed fixed-point operands (Q16.16 by
// default). One beat is taken in every cycle unless the pipeline is stalled; it passes
// through five front stages for products, sums, magnitudes and rounding, DATA_WIDTH + 2
// restoring division stages (DATA_WIDTH clamped to 16..32), one per quotient bit, and the
// output register. Every operation passes through the full pipeline, so results leave in
// order; a stall on the result channel while a result is held freezes the whole pipeline.
`default_nettype none

`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [1:0]                    req_operation,
   input  wire  [cau_pkg::FIELD_W-1:0]   req_a_real,
   input  wire  [cau_pkg::FIELD_W-1:0]   req_a_imag,
   input  wire  [cau_pkg::FIELD_W-1:0]   req_b_real,
   input  wire  [cau_pkg::FIELD_W-1:0]   req_b_imag,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [cau_pkg::FIELD_W-1:0]   rsp_result_real,
   output logic [cau_pkg::FIELD_W-1:0]   rsp_result_imag,
   output logic                          rsp_overflow,
   output logic                          rsp_divide_by_zero
);
   import cau_pkg::*;

   localparam int DW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
   localparam int FB = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
   localparam int PW = 2 * DW;
   localparam int CW = 3 * DW + FB + 3;
   localparam int RW = PW + 2;
   localparam int NS = DW + 2;
   localparam int QW = DW + 2;
   localparam logic [RW-1:0] LIM = {{(RW-1){1'b0}}, 1'b1} << (DW - 1);

   logic advance;

   ctl_type       f_ctl;
   logic [RW-1:0] f_mre, f_mim;
   logic [CW-1:0] f_rre, f_rim;
   logic [PW-1:0] f_den;
   logic          f_bre, f_bim;

   logic [QW-1:0] q_re, q_im;
   logic          big_re, big_im;

   ctl_type       dl_ctl_ff [NS];
   logic [RW-1:0] dl_mre_ff [NS];
   logic [RW-1:0] dl_mim_ff [NS];

   ctl_type       t_ctl;
   logic [QW:0]   qr_re, qr_im;
   logic [RW-1:0] mag_re, mag_im;
   logic          bg_re, bg_im, ov_re, ov_im;
   logic [DW-1:0] res_re, res_im;

   logic                 rsp_valid_ff;
   logic [FIELD_W-1:0]   rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;
   logic                 rsp_ov_ff, rsp_dz_ff, rsp_ov_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   cau_front #(.DW(DW), .FB(FB), .CW(CW), .RW(RW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_op      (op_type'(req_operation)),
      .in_a       (req_a_real),
      .in_b       (req_a_imag),
      .in_c       (req_b_real),
      .in_d       (req_b_imag),
      .out_ctl    (f_ctl),
      .out_mag_re (f_mre),
      .out_mag_im (f_mim),
      .out_rem_re (f_rre),
      .out_rem_im (f_rim),
      .out_den    (f_den),
      .out_big_re (f_bre),
      .out_big_im (f_bim)
   );

   cau_divider #(.DW(DW), .CW(CW)) u_div_re (
      .clock   (clock),
      .advance (advance),
      .rem_in  (f_rre),
      .den_in  (f_den),
      .big_in  (f_bre),
      .q_out   (q_re),
      .big_out (big_re)
   );

   cau_divider #(.DW(DW), .CW(CW)) u_div_im (
      .clock   (clock),
      .advance (advance),
      .rem_in  (f_rim),
      .den_in  (f_den),
      .big_in  (f_bim),
      .q_out   (q_im),
      .big_out (big_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            dl_ctl_ff[i] <= '0;
         end
      end else if (advance) begin
         dl_ctl_ff[0] <= f_ctl;
         for (int i = 1; i < NS; i++) begin
            dl_ctl_ff[i] <= dl_ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dl_mre_ff[0] <= f_mre;
         dl_mim_ff[0] <= f_mim;
         for (int i = 1; i < NS; i++) begin
            dl_mre_ff[i] <= dl_mre_ff[i-1];
            dl_mim_ff[i] <= dl_mim_ff[i-1];
         end
      end
   end

   always_comb begin
      t_ctl = dl_ctl_ff[NS-1];
      qr_re = ({1'b0, q_re} + {{QW{1'b0}}, 1'b1}) >> 1;
      qr_im = ({1'b0, q_im} + {{QW{1'b0}}, 1'b1}) >> 1;
      if (t_ctl.op == OP_DIV) begin
         mag_re = RW'(qr_re);
         mag_im = RW'(qr_im);
         bg_re  = big_re;
         bg_im  = big_im;
      end else begin
         mag_re = dl_mre_ff[NS-1];
         mag_im = dl_mim_ff[NS-1];
         bg_re  = 1'b0;
         bg_im  = 1'b0;
      end

      if (t_ctl.neg_re) begin
         ov_re  = bg_re || (mag_re > LIM);
         res_re = ov_re ? LIM[DW-1:0] : DW'(-mag_re);
      end else begin
         ov_re  = bg_re || (mag_re > LIM - 1'b1);
         res_re = ov_re ? DW'(LIM - 1'b1) : mag_re[DW-1:0];
      end
      if (t_ctl.neg_im) begin
         ov_im  = bg_im || (mag_im > LIM);
         res_im = ov_im ? LIM[DW-1:0] : DW'(-mag_im);
      end else begin
         ov_im  = bg_im || (mag_im > LIM - 1'b1);
         res_im = ov_im ? DW'(LIM - 1'b1) : mag_im[DW-1:0];
      end

      if (t_ctl.dz) begin
         rsp_re_in = '0;
         rsp_im_in = '0;
         rsp_ov_in = 1'b0;
      end else begin
         rsp_re_in = FIELD_W'($signed(res_re));
         rsp_im_in = FIELD_W'($signed(res_im));
         rsp_ov_in = ov_re || ov_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= t_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_re_ff <= rsp_re_in;
         rsp_im_ff <= rsp_im_in;
         rsp_ov_ff <= rsp_ov_in;
         rsp_dz_ff <= t_ctl.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_real    = rsp_re_ff;
   assign rsp_result_imag    = rsp_im_ff;
   assign rsp_overflow       = rsp_ov_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   `CAU_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid_ff && rsp_dz_ff, (rsp_re_ff == '0) && (rsp_im_ff == '0) && !rsp_ov_ff)
   `CAU_ASSERT_NXT(a_dz_div_only, clock, reset, advance && t_ctl.valid && (t_ctl.op != OP_DIV), rsp_valid_ff && !rsp_dz_ff)
   `CAU_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid_ff && rsp_stall)

endmodule

`default_nettype wire

/* bench/cau_checker.sv */
`timescale 1ns / 1ps

module cau_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_stall,
   input  wire [1:0]  req_operation,
   input  wire [31:0] req_a_real,
   input  wire [31:0] req_a_imag,
   input  wire [31:0] req_b_real,
   input  wire [31:0] req_b_imag,
   input  wire        rsp_valid,
   input  wire        rsp_stall,
   input  wire [31:0] rsp_result_real,
   input  wire [31:0] rsp_result_imag,
   input  wire        rsp_overflow,
   input  wire        rsp_divide_by_zero,
   output int         errors,
   output int         pending
);
   import cau_pkg::*;

   localparam int FB = 16;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        ovf;
      logic        dz;
   } cplx_result_t;

   cplx_result_t awaited_results[$];

   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
      if (v > 128'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -128'sd2147483648) begin
         ovf = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
      logic signed [127:0] mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (128'sd1 <<< (FB - 1))) >>> FB;
      return v < 0 ? -mag : mag;
   endfunction

   function automatic logic signed [127:0] div_q(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
      logic signed [127:0] mag, q, rem;
      mag = num < 0 ? -num : num;
      q = mag / den;
      if (q > (128'sd1 <<< 31))
         return num < 0 ? -q : q;
      q = (mag <<< FB) / den;
      rem = (mag <<< FB) % den;
      if ((rem <<< 1) >= den)
         q = q + 1;
      return num < 0 ? -q : q;
   endfunction

   function automatic cplx_result_t compute_cplx(input op_type op,
         input logic signed [31:0] a, b, c, d);
      cplx_result_t r;
      logic signed [127:0] sa, sb, sc, sd, den;
      sa = a;
      sb = b;
      sc = c;
      sd = d;
      r = '0;
      case (op)
         OP_ADD: begin
            r.re = clamp(sa + sc, r.ovf);
            r.im = clamp(sb + sd, r.ovf);
         end
         OP_SUB: begin
            r.re = clamp(sa - sc, r.ovf);
            r.im = clamp(sb - sd, r.ovf);
         end
         OP_MUL: begin
            r.re = clamp(round_q(sa * sc - sb * sd), r.ovf);
            r.im = clamp(round_q(sb * sc + sa * sd), r.ovf);
         end
         default: begin
            if (c == 0 && d == 0) begin
               r.dz = 1'b1;
            end else begin
               den = sc * sc + sd * sd;
               r.re = clamp(div_q(sa * sc + sb * sd, den), r.ovf);
               r.im = clamp(div_q(sb * sc - sa * sd, den), r.ovf);
            end
         end
      endcase
      return r;
   endfunction

   assign pending = awaited_results.size();

   initial errors = 0;

   always @(posedge clock) begin
      cplx_result_t want, got;
      if (!reset) begin
         if (req_valid && !req_stall)
            awaited_results.push_back(compute_cplx(op_type'(req_operation), req_a_real,
                                      req_a_imag, req_b_real, req_b_imag));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result_real, rsp_result_imag, rsp_overflow, rsp_divide_by_zero};
            if (awaited_results.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("Unexpected result beat: %h %h ovf %b dz %b",
                           got.re, got.im, got.ovf, got.dz);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("Mismatch: expected %h %h ovf %b dz %b, got %h %h ovf %b dz %b",
                              want.re, want.im, want.ovf, want.dz,
                              got.re, got.im, got.ovf, got.dz);
               end
            end
         end
      end
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import cau_pkg::*;

   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_a_real, req_a_imag, req_b_real, req_b_imag;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_real, rsp_result_imag;
   logic        rsp_overflow, rsp_divide_by_zero;
   int          errors, pending, idle_cycles;
   bit          stimulus_done;

   complex_arithmetic_unit u_top (.*);

   cau_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom;
         4: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         5, 6: return {{16{1'b0}}, 16'($urandom)} - 32'h00008000;
         default: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
      endcase
   endfunction

   task automatic send_beat(input op_type op, input logic [31:0] a, b, c, d);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_a_real <= a;
      req_a_imag <= b;
      req_b_real <= c;
      req_b_imag <= d;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_operation = '0;
      {req_a_real, req_a_imag, req_b_real, req_b_imag} = '0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < 4; i++) begin
         send_beat(op_type'(i), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
         send_beat(op_type'(i), 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
         send_beat(op_type'(i), 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
         send_beat(op_type'(i), 32'h00018000, 32'hfffe8000, 32'h00010000, 32'h00000001);
         send_beat(op_type'(i), 32'h0, 32'h0, 32'h0, 32'h0);
      end
      send_beat(OP_DIV, 32'h00010000, 32'h0, 32'h00030000, 32'h0);
      send_beat(OP_DIV, 32'hffff0000, 32'h0, 32'h00030000, 32'h0);
      send_beat(OP_MUL, 32'h00000001, 32'h0, 32'h00008000, 32'h0);
      send_beat(OP_MUL, 32'hffffffff, 32'h0, 32'h00008000, 32'h0);
      for (int i = 0; i < 550; i++) begin
         if (i == 275) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (pending != 0);
         end
         send_beat(op_type'($urandom_range(0, 3)), pick_part(), pick_part(), pick_part(),
                   $urandom_range(0, 7) == 0 ? 32'h0 : pick_part());
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(0, 14)) @(negedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      wait (stimulus_done);
      while (pending != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (pending == 0 && idle_cycles < WATCHDOG_LIMIT && errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT && !stimulus_done) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
